@@ hw/rtl/afs_pkg.sv @@
// ----------------------------------------------------------------------------
// afs_pkg
// Types, codes and constants shared by the actuator fail-safe supervisor.
// ----------------------------------------------------------------------------
package afs_pkg;

   localparam int unsigned CNT_W    = 16;
   localparam int unsigned PULSE_W  = 12;
   localparam int unsigned NUM_CH   = 4;
   localparam int unsigned CH_W     = 4;
   localparam int unsigned REQ_W    = 3;
   localparam int unsigned REPLY_W  = 3;
   localparam int unsigned PREQ_W   = 16;
   localparam int unsigned CSR_AW   = 5;
   localparam int unsigned CSR_DW   = 32;

   localparam logic [CNT_W-1:0]   CNT_MAX          = '1;
   localparam logic [CNT_W-1:0]   LINK_TIMEOUT_RST = 16'd1500;
   localparam logic [CNT_W-1:0]   HB_TIMEOUT_RST   = 16'd3000;
   localparam logic               LINK_CHECK_RST   = 1'b1;
   localparam logic [PULSE_W-1:0] SAFE_PULSE_RST   = 12'd500;

   localparam logic [PREQ_W-1:0]  PRESET_LOW_US    = 16'd500;
   localparam logic [PREQ_W-1:0]  PRESET_MID_US    = 16'd1500;
   localparam logic [PREQ_W-1:0]  PRESET_HIGH_US   = 16'd2500;

   localparam logic [CH_W-1:0]    CH_FIRST         = 4'd1;
   localparam logic [CH_W-1:0]    CH_LAST          = 4'd4;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK      = 3'd0,
      REQ_PING      = 3'd1,
      REQ_ABORT     = 3'd2,
      REQ_RESET     = 3'd3,
      REQ_MOVE      = 3'd4,
      REQ_STATUS    = 3'd5,
      REQ_SOLENOID  = 3'd6,
      REQ_HEARTBEAT = 3'd7
   } req_kind_type;

   typedef enum logic [REPLY_W-1:0] {
      REPLY_SILENT      = 3'd0,
      REPLY_OK          = 3'd1,
      REPLY_REFUSED     = 3'd2,
      REPLY_BAD_SERVO   = 3'd3,
      REPLY_NO_SOLENOID = 3'd4,
      REPLY_UNKNOWN     = 3'd5
   } reply_type;

   typedef enum logic [2:0] {
      CSR_LINK_TIMEOUT = 3'd0,
      CSR_HB_TIMEOUT   = 3'd1,
      CSR_LINK_CHECK   = 3'd2,
      CSR_SAFE_CH1     = 3'd3,
      CSR_SAFE_CH2     = 3'd4,
      CSR_SAFE_CH3     = 3'd5,
      CSR_SAFE_CH4     = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [CNT_W-1:0]                link_timeout;
      logic [CNT_W-1:0]                hb_timeout;
      logic                            link_check_en;
      logic [NUM_CH-1:0][PULSE_W-1:0]  safe_pulse;
   } cfg_type;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic              is_unknown;
      logic [CH_W-1:0]   servo_channel;
      logic [PREQ_W-1:0] servo_pulse_req;
   } item_type;

   typedef struct packed {
      logic [REPLY_W-1:0]              reply_code;
      logic [NUM_CH-1:0][PULSE_W-1:0]  pulse;
      logic                            failsafe_active;
      logic                            can_fault_flag;
      logic                            link_loss_event;
      logic                            heartbeat_lost_event;
      logic                            heartbeat_back_event;
   } result_type;

endpackage

@@ hw/rtl/afs_req_if.sv @@
// ----------------------------------------------------------------------------
// afs_req_if
// Request channel: each word is a tick, an operator command or a heartbeat.
// ----------------------------------------------------------------------------
interface afs_req_if
   import afs_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic                is_unknown;
   logic [CH_W-1:0]     servo_channel;
   logic [PREQ_W-1:0]   servo_pulse_req;

   modport source (
      output valid, req_type, is_unknown, servo_channel, servo_pulse_req,
      input  ready
   );

   modport sink (
      input  valid, req_type, is_unknown, servo_channel, servo_pulse_req,
      output ready
   );
endinterface

@@ hw/rtl/afs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// afs_rsp_if
// Response channel: reply code, channel pulses, flags and events per word.
// ----------------------------------------------------------------------------
interface afs_rsp_if
   import afs_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [REPLY_W-1:0]  reply_code;
   logic [PULSE_W-1:0]  pulse_ch1;
   logic [PULSE_W-1:0]  pulse_ch2;
   logic [PULSE_W-1:0]  pulse_ch3;
   logic [PULSE_W-1:0]  pulse_ch4;
   logic                failsafe_active;
   logic                can_fault_flag;
   logic                link_loss_event;
   logic                heartbeat_lost_event;
   logic                heartbeat_back_event;

   modport source (
      output valid, reply_code, pulse_ch1, pulse_ch2, pulse_ch3, pulse_ch4,
             failsafe_active, can_fault_flag, link_loss_event,
             heartbeat_lost_event, heartbeat_back_event,
      input  ready
   );

   modport sink (
      input  valid, reply_code, pulse_ch1, pulse_ch2, pulse_ch3, pulse_ch4,
             failsafe_active, can_fault_flag, link_loss_event,
             heartbeat_lost_event, heartbeat_back_event,
      output ready
   );
endinterface

@@ hw/rtl/afs_csr.sv @@
// ----------------------------------------------------------------------------
// afs_csr
// Configuration register file behind an APB-style write/read port.
// ----------------------------------------------------------------------------
module afs_csr
   import afs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_idx_type idx;
   logic        wr_en;

   assign idx        = csr_idx_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            CSR_LINK_TIMEOUT: cfg_in.link_timeout  = csr_pwdata[CNT_W-1:0];
            CSR_HB_TIMEOUT:   cfg_in.hb_timeout    = csr_pwdata[CNT_W-1:0];
            CSR_LINK_CHECK:   cfg_in.link_check_en = csr_pwdata[0];
            CSR_SAFE_CH1:     cfg_in.safe_pulse[0] = csr_pwdata[PULSE_W-1:0];
            CSR_SAFE_CH2:     cfg_in.safe_pulse[1] = csr_pwdata[PULSE_W-1:0];
            CSR_SAFE_CH3:     cfg_in.safe_pulse[2] = csr_pwdata[PULSE_W-1:0];
            CSR_SAFE_CH4:     cfg_in.safe_pulse[3] = csr_pwdata[PULSE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_LINK_TIMEOUT: csr_prdata = CSR_DW'(cfg_ff.link_timeout);
         CSR_HB_TIMEOUT:   csr_prdata = CSR_DW'(cfg_ff.hb_timeout);
         CSR_LINK_CHECK:   csr_prdata = CSR_DW'(cfg_ff.link_check_en);
         CSR_SAFE_CH1:     csr_prdata = CSR_DW'(cfg_ff.safe_pulse[0]);
         CSR_SAFE_CH2:     csr_prdata = CSR_DW'(cfg_ff.safe_pulse[1]);
         CSR_SAFE_CH3:     csr_prdata = CSR_DW'(cfg_ff.safe_pulse[2]);
         CSR_SAFE_CH4:     csr_prdata = CSR_DW'(cfg_ff.safe_pulse[3]);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_timeout  <= LINK_TIMEOUT_RST;
         cfg_ff.hb_timeout    <= HB_TIMEOUT_RST;
         cfg_ff.link_check_en <= LINK_CHECK_RST;
         cfg_ff.safe_pulse    <= {NUM_CH{SAFE_PULSE_RST}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/afs_core.sv @@
// ----------------------------------------------------------------------------
// afs_core
// Supervisor state and the single-pass update for one word.
// ----------------------------------------------------------------------------
module afs_core
   import afs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [CNT_W-1:0]               link_cnt_ff, link_cnt_in;
   logic [CNT_W-1:0]               hb_cnt_ff, hb_cnt_in;
   logic                           latched_ff, latched_in;
   logic                           fault_ff, fault_in;
   logic [NUM_CH-1:0][PULSE_W-1:0] pulse_ff, pulse_in;
   reply_type                      reply;
   logic                           link_ev;
   logic                           lost_ev;
   logic                           back_ev;
   req_kind_type                   kind;
   logic                           chan_ok;
   logic                           preset_ok;
   logic [CH_W-1:0]                chan_off;

   assign kind      = req_kind_type'(item.req_type);
   assign chan_ok   = item.servo_channel inside {[CH_FIRST:CH_LAST]};
   assign preset_ok = item.servo_pulse_req inside
                      {PRESET_LOW_US, PRESET_MID_US, PRESET_HIGH_US};
   assign chan_off  = item.servo_channel - CH_FIRST;

   always_comb begin
      link_cnt_in = link_cnt_ff;
      hb_cnt_in   = hb_cnt_ff;
      latched_in  = latched_ff;
      fault_in    = fault_ff;
      pulse_in    = pulse_ff;
      reply       = REPLY_SILENT;
      link_ev     = 1'b0;
      lost_ev     = 1'b0;
      back_ev     = 1'b0;

      if (item.is_unknown) begin
         link_cnt_in = '0;
         reply       = REPLY_UNKNOWN;
      end else begin
         case (kind)
            REQ_TICK: begin
               link_cnt_in = (link_cnt_ff == CNT_MAX) ? link_cnt_ff
                                                      : link_cnt_ff + 1'b1;
               hb_cnt_in   = (hb_cnt_ff == CNT_MAX) ? hb_cnt_ff
                                                    : hb_cnt_ff + 1'b1;
            end
            REQ_HEARTBEAT: begin
               hb_cnt_in = '0;
               if (fault_ff) begin
                  fault_in = 1'b0;
                  back_ev  = 1'b1;
               end
            end
            default: begin
               link_cnt_in = '0;
               case (kind)
                  REQ_PING: reply = REPLY_SILENT;
                  REQ_ABORT: begin
                     pulse_in   = cfg.safe_pulse;
                     latched_in = 1'b1;
                     reply      = REPLY_OK;
                  end
                  REQ_RESET: begin
                     latched_in = 1'b0;
                     reply      = REPLY_OK;
                  end
                  REQ_MOVE: begin
                     if (latched_ff) begin
                        reply = REPLY_REFUSED;
                     end else if (chan_ok && preset_ok) begin
                        pulse_in[chan_off[1:0]] = item.servo_pulse_req[PULSE_W-1:0];
                        reply = REPLY_OK;
                     end else begin
                        reply = REPLY_BAD_SERVO;
                     end
                  end
                  REQ_STATUS: reply = REPLY_OK;
                  default:    reply = REPLY_NO_SOLENOID;
               endcase
            end
         endcase
      end

      if (cfg.link_check_en && !latched_in && (link_cnt_in > cfg.link_timeout)) begin
         pulse_in   = cfg.safe_pulse;
         latched_in = 1'b1;
         link_ev    = 1'b1;
      end
      if (!fault_in && (hb_cnt_in > cfg.hb_timeout)) begin
         fault_in = 1'b1;
         lost_ev  = 1'b1;
      end
   end

   always_comb begin
      result.reply_code           = reply;
      result.pulse                = pulse_in;
      result.failsafe_active      = latched_in;
      result.can_fault_flag       = fault_in;
      result.link_loss_event      = link_ev;
      result.heartbeat_lost_event = lost_ev;
      result.heartbeat_back_event = back_ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_cnt_ff <= '0;
         hb_cnt_ff   <= '0;
         latched_ff  <= 1'b1;
         fault_ff    <= 1'b1;
         pulse_ff    <= {NUM_CH{SAFE_PULSE_RST}};
      end else if (step) begin
         link_cnt_ff <= link_cnt_in;
         hb_cnt_ff   <= hb_cnt_in;
         latched_ff  <= latched_in;
         fault_ff    <= fault_in;
         pulse_ff    <= pulse_in;
      end
   end

endmodule

@@ hw/rtl/actuator_failsafe_supervisor.sv @@
// ----------------------------------------------------------------------------
// actuator_failsafe_supervisor
// Fail-safe supervisor for four servo valves with link and heartbeat watchdogs.
// ----------------------------------------------------------------------------
// Each word on req_chan is a 1 ms tick, an operator command or an
// instrumentation heartbeat. Every accepted word yields exactly one word on
// rsp_chan with the reply code, the four commanded pulses, the fail-safe and
// CAN fault flags and the event bits raised by that word.
// A word sits in an input register, passes the update logic and lands in the
// response register, from which it is offered on rsp_chan. One word is taken
// per cycle while rsp_chan is not stalled; the update of the counters
// and flags is a single compare-and-select pass, which sets that rate.
// When rsp_chan stalls, the response register holds its word and the input
// register keeps one more; req_chan.ready falls only when both are full.
// Reset clears both channels, loads the register defaults, latches fail-safe,
// sets the CAN fault and drives every channel to 500 us.
// The csr_ port writes a register at byte address 4*i in the access phase and
// returns its value on csr_prdata; the user must write only while idle (not enforced).
// ----------------------------------------------------------------------------
module actuator_failsafe_supervisor
   import afs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   afs_req_if.sink           req_chan,
   afs_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type res_ff, res_in;
   logic       out_valid_ff, out_valid_in;
   logic       step;
   logic       req_take;

   afs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   afs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (res_in)
   );

   assign step           = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | step;
   assign req_take       = req_chan.valid & req_chan.ready;

   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.req_type        = req_chan.req_type;
         item_in.is_unknown      = req_chan.is_unknown;
         item_in.servo_channel   = req_chan.servo_channel;
         item_in.servo_pulse_req = req_chan.servo_pulse_req;
      end
      in_valid_in  = req_take | (in_valid_ff & ~step);
      out_valid_in = step | (out_valid_ff & ~rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (step) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid                = out_valid_ff;
   assign rsp_chan.reply_code           = res_ff.reply_code;
   assign rsp_chan.pulse_ch1            = res_ff.pulse[0];
   assign rsp_chan.pulse_ch2            = res_ff.pulse[1];
   assign rsp_chan.pulse_ch3            = res_ff.pulse[2];
   assign rsp_chan.pulse_ch4            = res_ff.pulse[3];
   assign rsp_chan.failsafe_active      = res_ff.failsafe_active;
   assign rsp_chan.can_fault_flag       = res_ff.can_fault_flag;
   assign rsp_chan.link_loss_event      = res_ff.link_loss_event;
   assign rsp_chan.heartbeat_lost_event = res_ff.heartbeat_lost_event;
   assign rsp_chan.heartbeat_back_event = res_ff.heartbeat_back_event;

   a_link_loss_latches: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && res_ff.link_loss_event) |-> res_ff.failsafe_active)
      else $error("link loss reported without fail-safe latched");

   a_hb_events_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(res_ff.heartbeat_lost_event && res_ff.heartbeat_back_event))
      else $error("heartbeat lost and back reported together");

   a_hb_back_clears: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && res_ff.heartbeat_back_event && !res_ff.heartbeat_lost_event)
      |-> !res_ff.can_fault_flag)
      else $error("heartbeat back reported with CAN fault still set");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (in_valid_ff && out_valid_ff && !rsp_chan.ready))
      else $error("request stalled with room in the pipeline");

endmodule
